FILE: hdl/fan_step_table_hysteresis_unit_assert.svh
// ----------------------------------------------------------------------------
// Fan step table assertion macros
// Concurrent assertion helpers for the fan step table unit, clocked on clk and
// disabled during rst. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef FAN_STEP_TABLE_HYSTERESIS_UNIT_ASSERT_SVH
`define FAN_STEP_TABLE_HYSTERESIS_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define FSTH_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fan step table assertion failed");
// Next-cycle implication.
`define FSTH_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fan step table assertion failed");
`else
`define FSTH_ASSERT_IMP(lbl, ante, cons)
`define FSTH_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/fsth_pkg.sv
// ----------------------------------------------------------------------------
// Fan step table package
// Widths, register indexes, entry field positions and the types shared by the
// register file and the level sequencer.
// ----------------------------------------------------------------------------
package fsth_pkg;

  localparam int LEVEL_W    = 3;
  localparam int TEMP_W     = 8;
  localparam int RPM_W      = 16;
  localparam int ENTRY_W    = 48;
  localparam int TABLE_REGS = 7;
  localparam int ADDR_W     = 6;
  localparam int DATA_W     = 64;

  // Register index of the level count; indexes below it are table entries.
  localparam logic [LEVEL_W-1:0] REG_LEVELS_IN_USE = 3'd7;

  // Field positions inside one table entry.
  localparam int ON_LSB   = 0;
  localparam int OFF_LSB  = 8;
  localparam int RPM0_LSB = 16;
  localparam int RPM1_LSB = 32;

  // Read request from the sequencer into the register file.
  typedef struct packed {
    logic               busy;
    logic [LEVEL_W-1:0] idx;
  } tbl_req_t;

  // Table contents seen by the sequencer.
  typedef struct packed {
    logic [ENTRY_W-1:0] entry;
    logic [LEVEL_W-1:0] levels;
  } tbl_rd_t;

endpackage

FILE: hdl/fsth_regs.sv
// ----------------------------------------------------------------------------
// Fan step table register file
// Holds the seven level entries and the level count behind an APB-style port.
// The sequencer has its own entry read port; bus reads use the register index.
// ----------------------------------------------------------------------------
module fsth_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsth_pkg::ADDR_W-1:0]  paddr,
  input  logic [fsth_pkg::DATA_W-1:0]  pwdata,
  output logic [fsth_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  input  fsth_pkg::tbl_req_t           req,
  output fsth_pkg::tbl_rd_t            tbl
);

  logic [fsth_pkg::ENTRY_W-1:0] entries [fsth_pkg::TABLE_REGS];
  logic [fsth_pkg::LEVEL_W-1:0] levels;
  logic [fsth_pkg::LEVEL_W-1:0] reg_idx;
  logic [fsth_pkg::LEVEL_W-1:0] rd_idx;
  logic [fsth_pkg::ENTRY_W-1:0] rd_entry;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[fsth_pkg::ADDR_W-1:3];
  assign wr_en   = psel & penable & pwrite & pready;

  // Register writes; the level count keeps its low three bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < fsth_pkg::TABLE_REGS; i++) begin
        entries[i] <= '0;
      end
      levels <= fsth_pkg::LEVEL_W'(1);
    end else if (wr_en) begin
      if (reg_idx == fsth_pkg::REG_LEVELS_IN_USE) begin
        levels <= pwdata[fsth_pkg::LEVEL_W-1:0];
      end else begin
        entries[reg_idx] <= pwdata[fsth_pkg::ENTRY_W-1:0];
      end
    end
  end

  // The sequencer reads the entry it asks for while it works.
  assign rd_idx = req.busy ? req.idx : reg_idx;

  always_comb begin
    if (rd_idx == fsth_pkg::REG_LEVELS_IN_USE) begin
      rd_entry = '0;
    end else begin
      rd_entry = entries[rd_idx];
    end
  end

  // Bus read data always follows the addressed register.
  always_comb begin
    if (reg_idx == fsth_pkg::REG_LEVELS_IN_USE) begin
      prdata = fsth_pkg::DATA_W'(levels);
    end else begin
      prdata = fsth_pkg::DATA_W'(entries[reg_idx]);
    end
  end

  assign tbl.entry  = rd_entry;
  assign tbl.levels = levels;

endmodule

FILE: hdl/fan_step_table_hysteresis_unit.sv
// Sequence: an accepted request with the system on walks the level one level step a cycle
// until a compare or a table bound stops it, then clamps it and loads the result once the
// output is free; a sample equal to the previous one skips the walk.
// Throughput: one request at a time; the next is taken in the cycle after the result is
// loaded into the output register, even while that result still waits to be taken.
// Reset (rst, synchronous): level 0, previous sample 0, table cleared, one level in use.
// ----------------------------------------------------------------------------
// Fan step table with hysteresis
// Walks the fan level up or down through the step table, one level compare a
// cycle on a shared signed comparator, then returns the selected fan's rpm.
// ----------------------------------------------------------------------------
`include "fan_step_table_hysteresis_unit_assert.svh"

module fan_step_table_hysteresis_unit #(
  parameter int MAX_LEVELS   = 7,
  parameter int FAN_CHANNELS = 2
) (
  input  logic                         clk,
  input  logic                         rst,
  // Input requests
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic [7:0]                   s_tdata,   // [7:0] temperature (signed)
  input  logic [1:0]                   s_tuser,   // [0] fan_index, [1] system_on
  // Results
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic [23:0]                  m_tdata,   // [15:0] target_rpm, [18:16] fan_level
  // Configuration
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fsth_pkg::ADDR_W-1:0]  paddr,
  input  logic [fsth_pkg::DATA_W-1:0]  pwdata,
  output logic [fsth_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLAMP,
    ST_RESULT
  } state_t;

  localparam logic [fsth_pkg::LEVEL_W-1:0] MAX_LVL = fsth_pkg::LEVEL_W'(MAX_LEVELS);
  localparam logic [fsth_pkg::LEVEL_W-1:0] LVL_ONE = fsth_pkg::LEVEL_W'(1);

  state_t                        state;
  logic [fsth_pkg::LEVEL_W-1:0]  stored_level;
  logic [fsth_pkg::TEMP_W-1:0]   last_temp;
  logic [fsth_pkg::TEMP_W-1:0]   temp;
  logic                          fan;
  logic                          walk_down;
  logic [fsth_pkg::LEVEL_W-1:0]  idx;
  logic [fsth_pkg::LEVEL_W-1:0]  lvl;

  fsth_pkg::tbl_req_t            req;
  fsth_pkg::tbl_rd_t             tbl;
  logic [fsth_pkg::LEVEL_W-1:0]  n_eff;
  logic [fsth_pkg::TEMP_W-1:0]   thr;
  logic                          below;
  logic                          out_free;
  logic                          in_fire;
  logic                          fan_in;
  logic [fsth_pkg::RPM_W-1:0]    rpm;

  fsth_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req),
    .tbl     (tbl)
  );

  assign req.busy = (state != ST_IDLE);
  assign req.idx  = idx;

  // Effective level count: zero acts as one, anything above the table size is capped.
  always_comb begin
    if (tbl.levels == '0) begin
      n_eff = LVL_ONE;
    end else if (tbl.levels > MAX_LVL) begin
      n_eff = MAX_LVL;
    end else begin
      n_eff = tbl.levels;
    end
  end

  // Shared comparator: sample against the off threshold going down, the on threshold going up.
  assign thr   = walk_down ? tbl.entry[fsth_pkg::OFF_LSB +: fsth_pkg::TEMP_W]
                           : tbl.entry[fsth_pkg::ON_LSB +: fsth_pkg::TEMP_W];
  assign below = $signed(temp) < $signed(thr);

  assign rpm = fan ? tbl.entry[fsth_pkg::RPM1_LSB +: fsth_pkg::RPM_W]
                   : tbl.entry[fsth_pkg::RPM0_LSB +: fsth_pkg::RPM_W];

  assign fan_in   = (FAN_CHANNELS > 1) ? s_tuser[0] : 1'b0;
  assign s_tready = (state == ST_IDLE);
  assign in_fire  = s_tvalid & s_tready;
  assign out_free = ~m_tvalid | m_tready;

  // Sequencer, level state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      stored_level <= '0;
      last_temp    <= '0;
      m_tvalid     <= 1'b0;
    end else begin
      // Output valid is set when a result is loaded and cleared once it is taken.
      if (state == ST_RESULT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire && s_tuser[1]) begin
            temp      <= s_tdata;
            fan       <= fan_in;
            idx       <= stored_level;
            lvl       <= stored_level;
            walk_down <= $signed(s_tdata) < $signed(last_temp);
            state     <= (s_tdata == last_temp) ? ST_CLAMP : ST_WALK;
          end
        end
        ST_WALK: begin
          if (walk_down) begin
            // Step down while the sample is below this level's off threshold.
            if (idx != '0 && below) begin
              lvl <= idx - LVL_ONE;
              idx <= idx - LVL_ONE;
            end else begin
              state <= ST_CLAMP;
            end
          end else begin
            // Step up while the sample reaches this level's on threshold.
            if (idx < n_eff && !below) begin
              lvl <= idx;
              idx <= idx + LVL_ONE;
            end else begin
              state <= ST_CLAMP;
            end
          end
        end
        ST_CLAMP: begin
          if (lvl >= n_eff) begin
            lvl <= n_eff - LVL_ONE;
            idx <= n_eff - LVL_ONE;
          end else begin
            idx <= lvl;
          end
          state <= ST_RESULT;
        end
        ST_RESULT: begin
          if (out_free) begin
            stored_level <= lvl;
            last_temp    <= temp;
            m_tdata      <= {5'b0, lvl, rpm};
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The stored level never leaves the table.
  `FSTH_ASSERT_IMP(a_level_in_table, 1'b1, stored_level < MAX_LVL)
  // A loaded result carries the level that has just been stored.
  `FSTH_ASSERT_NEXT(a_result_level, (state == ST_RESULT) && out_free,
                    m_tvalid && (m_tdata[18:16] == stored_level))
  // A request with the system off changes nothing and starts no walk.
  `FSTH_ASSERT_NEXT(a_off_no_update, in_fire && !s_tuser[1],
                    (state == ST_IDLE) && $stable(stored_level) && $stable(last_temp))
  // While walking the chosen level stays inside the table.
  `FSTH_ASSERT_IMP(a_walk_level, state == ST_WALK, lvl < MAX_LVL)

endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Fan step table unit testbench
// Drives temperature requests into the step table unit and programmes the
// level table over the register port. A local predictor follows the level
// walk with hysteresis and queues the expected rpm target and level. Each
// result is checked against the oldest queued value. Both stream sides idle
// and stall at random.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_TARGET = 700;
  localparam int RANDOM_PHASES = 10;
  localparam int ENTRY_REGS = fsth_pkg::TABLE_REGS;
  localparam logic [2:0] REG_LEVELS = fsth_pkg::REG_LEVELS_IN_USE;

  // One expected result: rpm target and the level that was chosen.
  typedef struct packed {
    logic [15:0] rpm;
    logic [2:0]  level;
  } fan_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;   // [7:0] temperature (signed)
  logic [1:0]  s_tuser = 2'b00;   // [0] fan_index, [1] system_on
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;           // [15:0] target_rpm, [18:16] fan_level
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [fsth_pkg::ADDR_W-1:0] paddr = '0;
  logic [fsth_pkg::DATA_W-1:0] pwdata = '0;
  logic [fsth_pkg::DATA_W-1:0] prdata;
  logic        pready;

  // Predictor state and its copy of the registers.
  logic [47:0]       level_tbl [0:6];
  logic [2:0]        levels_cfg;
  logic [2:0]        cur_level;
  logic signed [7:0] last_temp;
  fan_result_t       pending_speeds [$];
  fan_result_t       head_speed;

  int  error_count = 0;
  int  powered_sent = 0;
  int  results_seen = 0;
  int  cycle_count = 0;
  bit  send_burst = 1'b0;
  bit  recv_burst = 1'b0;

  fan_step_table_hysteresis_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #1 clk = ~clk;

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
               pending_speeds.size());
      $display("testbench: done, errors");
      $finish;
    end
  end

  function automatic void flag_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  // Walk the level for one powered sample and queue the result it gives.
  function automatic void predict_fan_speed(input logic signed [7:0] t, input logic fan);
    int                lim;
    int                lvl;
    int                i;
    bit                walking;
    logic signed [7:0] thr;
    fan_result_t       r;
    lim = (levels_cfg == 3'd0) ? 1 : int'(levels_cfg);
    lvl = int'(cur_level);
    walking = 1'b1;
    // Cooling: drop while below the current level's off threshold.
    if (t < last_temp) begin
      i = lvl;
      while (walking && i > 0) begin
        thr = level_tbl[i][15:8];
        if (t < thr) begin
          lvl = i - 1;
          i--;
        end else begin
          walking = 1'b0;
        end
      end
    end else if (t > last_temp) begin
      // Warming: climb while the sample reaches the on threshold.
      i = lvl;
      while (walking && i < lim) begin
        thr = level_tbl[i][7:0];
        if (t >= thr) begin
          lvl = i;
          i++;
        end else begin
          walking = 1'b0;
        end
      end
    end
    if (lvl >= lim) lvl = lim - 1;
    cur_level = 3'(lvl);
    last_temp = t;
    r.rpm = fan ? level_tbl[lvl][47:32] : level_tbl[lvl][31:16];
    r.level = 3'(lvl);
    pending_speeds.push_back(r);
  endfunction

  function automatic logic [47:0] pack_level(input int on_t, input int off_t,
                                             input logic [15:0] rpm0,
                                             input logic [15:0] rpm1);
    return {rpm1, rpm0, 8'(off_t), 8'(on_t)};
  endfunction

  function automatic logic [15:0] pick_rpm();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // Send one temperature request; the prediction for a powered sample is made once it is taken.
  task automatic send_sample(input logic signed [7:0] t, input logic fan, input logic on);
    int gap;
    if ($urandom_range(0, 19) == 0) send_burst = ~send_burst;
    gap = send_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= t;
    s_tuser  <= {on, fan};
    do @(posedge clk); while (!s_tready);
    if (on) begin
      predict_fan_speed(t, fan);
      powered_sent++;
    end
  endtask

  // Register write: setup cycle, access cycle, then idle.
  task automatic write_reg(input logic [2:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (idx < ENTRY_REGS) level_tbl[idx] = value[47:0];
    else levels_cfg = value[2:0];
    @(posedge clk);
  endtask

  // Wait until every expected result is in and the unit has gone quiet.
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_speeds.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // After reset the table is clear and one level is in use.
  task automatic test_reset_state();
    send_sample(8'h00, 1'b0, 1'b1);
    send_sample(8'h7F, 1'b1, 1'b1);
    send_sample(8'h80, 1'b0, 1'b1);
    send_sample(8'h05, 1'b1, 1'b0);
    send_sample(8'h05, 1'b0, 1'b1);
    settle();
  endtask

  // Ordered table: full climb and fall, equal samples, system off, a zero
  // level count, and the level count lowered beneath the current level.
  task automatic test_level_walk();
    int i;
    int on_t;
    for (i = 0; i < ENTRY_REGS; i++) begin
      on_t = (i == 6) ? 120 : -100 + 36 * i;
      write_reg(3'(i), {16'h0000, pack_level(on_t, on_t - 5,
                        (i == 6) ? 16'hFFFF : 16'(1000 * i),
                        (i == 6) ? 16'h0000 : 16'(60000 - 1000 * i))});
    end
    write_reg(REG_LEVELS, 64'd7);
    send_sample(8'h7F, 1'b0, 1'b1);
    send_sample(8'h7F, 1'b1, 1'b1);
    send_sample(8'h80, 1'b0, 1'b0);
    send_sample(8'd50, 1'b1, 1'b1);
    send_sample(8'h80, 1'b0, 1'b1);
    send_sample(8'h00, 1'b1, 1'b1);
    settle();
    // A level count of zero behaves as a single level.
    write_reg(REG_LEVELS, 64'd0);
    send_sample(8'h7F, 1'b0, 1'b1);
    send_sample(8'h80, 1'b1, 1'b1);
    settle();
    write_reg(REG_LEVELS, 64'd7);
    send_sample(8'd126, 1'b0, 1'b1);
    settle();
    // Rising sample above a shrunken table: no climb, only the clamp.
    write_reg(REG_LEVELS, 64'd2);
    send_sample(8'h7F, 1'b1, 1'b1);
    settle();
    write_reg(REG_LEVELS, 64'd7);
    send_sample(8'h80, 1'b0, 1'b1);
    send_sample(8'd126, 1'b1, 1'b1);
    settle();
    // Falling sample above a shrunken table still reads the stored entries.
    write_reg(REG_LEVELS, 64'd3);
    send_sample(8'd100, 1'b0, 1'b1);
    settle();
  endtask

  // Random tables and level counts; temperatures follow a drifting walk so
  // the hysteresis bands are crossed in both directions, with some noise.
  task automatic test_random_walks();
    int          phase;
    int          i;
    int          kind;
    int          base;
    int          spacing;
    int          on_t;
    int          off_t;
    int          temp;
    int          roll;
    int          phase_start;
    logic [2:0]  lv;
    logic [47:0] e;
    logic [63:0] word;
    temp = 0;
    for (phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = $urandom_range(0, 2);
      base = $urandom_range(0, 80) - 128;
      spacing = $urandom_range(4, 40);
      for (i = 0; i < ENTRY_REGS; i++) begin
        if (kind == 0) begin
          e = {16'($urandom), 32'($urandom)};
        end else begin
          on_t = base + i * spacing;
          if (on_t > 127) on_t = 127;
          off_t = on_t - $urandom_range(0, 15);
          if (off_t < -128) off_t = -128;
          e = pack_level(on_t, off_t, pick_rpm(), pick_rpm());
        end
        write_reg(3'(i), {16'($urandom), e});
      end
      case (phase)
        0, 4, 9: lv = 3'd7;
        1:       lv = 3'd1;
        2:       lv = 3'd0;
        default: lv = 3'($urandom_range(2, 6));
      endcase
      word = {32'($urandom), 32'($urandom)};
      word[2:0] = lv;
      write_reg(REG_LEVELS, word);
      phase_start = powered_sent;
      while (powered_sent - phase_start < RANDOM_TARGET / RANDOM_PHASES) begin
        roll = $urandom_range(0, 99);
        if (roll >= 8 && roll < 20) temp = $urandom_range(0, 255) - 128;
        else temp += $urandom_range(0, 24) - 12;
        if (temp > 127) temp = 127;
        if (temp < -128) temp = -128;
        send_sample(8'(temp), 1'($urandom_range(0, 1)), roll >= 8);
      end
      settle();
    end
  endtask

  // Result sink with random stalls between results.
  initial begin : result_sink
    int stall;
    forever begin
      if ($urandom_range(0, 19) == 0) recv_burst = ~recv_burst;
      stall = recv_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_speeds.size() == 0) begin
        flag_error($sformatf("result with none expected: rpm %0d level %0d",
                             m_tdata[15:0], m_tdata[18:16]));
      end else begin
        head_speed = pending_speeds.pop_front();
        if (m_tdata[15:0] !== head_speed.rpm)
          flag_error($sformatf("target_rpm expected %0d actual %0d",
                               head_speed.rpm, m_tdata[15:0]));
        if (m_tdata[18:16] !== head_speed.level)
          flag_error($sformatf("fan_level expected %0d actual %0d",
                               head_speed.level, m_tdata[18:16]));
      end
    end
  end

  // Reset, then each test in turn.
  initial begin
    int i;
    for (i = 0; i < ENTRY_REGS; i++) level_tbl[i] = '0;
    levels_cfg = 3'd1;
    cur_level = 3'd0;
    last_temp = 8'sd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_level_walk();
    test_random_walks();
    $display("summary: %0d powered samples sent, %0d results checked, %0d errors",
             powered_sent, results_seen, error_count);
    $display("summary: reset state, ordered walk, level count edits, %0d random tables",
             RANDOM_PHASES);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
